### hw/rtl/fpip_pkg.sv
// shared types and constants for the binary64 integer power block
package fpip_pkg;

	localparam int unsigned EXP_BITS_DEF = 32;

	localparam logic [63:0] FP_ONE       = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] FP_NAN_DFLT  = 64'hFFF8_0000_0000_0000;
	localparam int unsigned QUIET_BIT    = 51;

	typedef enum logic {
		OP_MUL,
		OP_RECIP
	} fpip_op_t;

	typedef struct packed {
		logic     start;
		fpip_op_t op;
	} fpip_req_t;

endpackage

### hw/rtl/fpip_fpu.sv
// iterative binary64 multiply and reciprocal unit on one 32x32 multiplier
module fpip_fpu
	import fpip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fpip_req_t   req,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_DIVPRE,
		F_DIV,
		F_NORM,
		F_DENORM,
		F_ROUND
	} fst_t;

	fst_t               st_q;
	logic               done_q;
	logic [63:0]        res_q;
	logic               sign_q;
	logic [52:0]        ma_q;
	logic [52:0]        mb_q;
	logic [105:0]       acc_q;
	logic [63:0]        prod_q;
	logic [53:0]        rem_q;
	logic [5:0]         cnt_q;
	logic signed [13:0] rexp_q;
	logic               stk_q;

	// operand unpack
	logic        a_sign, b_sign;
	logic [10:0] a_exp, b_exp;
	logic [51:0] a_frac, b_frac;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [10:0] a_eff, b_eff;

	always_comb begin
		a_sign = a[63];
		b_sign = b[63];
		a_exp  = a[62:52];
		b_exp  = b[62:52];
		a_frac = a[51:0];
		b_frac = b[51:0];
		a_nan  = (a_exp == 11'h7FF) && (a_frac != 52'd0);
		b_nan  = (b_exp == 11'h7FF) && (b_frac != 52'd0);
		a_inf  = (a_exp == 11'h7FF) && (a_frac == 52'd0);
		b_inf  = (b_exp == 11'h7FF) && (b_frac == 52'd0);
		a_zero = (a_exp == 11'd0) && (a_frac == 52'd0);
		b_zero = (b_exp == 11'd0) && (b_frac == 52'd0);
		a_eff  = (a_exp == 11'd0) ? 11'd1 : a_exp;
		b_eff  = (b_exp == 11'd0) ? 11'd1 : b_exp;
	end

	// partial product operand select
	logic [31:0]  mul_x, mul_y;
	logic [5:0]   pcnt;
	logic [105:0] prod_ext, prod_sh;

	always_comb begin
		mul_x    = cnt_q[1] ? {11'd0, ma_q[52:32]} : ma_q[31:0];
		mul_y    = cnt_q[0] ? {11'd0, mb_q[52:32]} : mb_q[31:0];
		pcnt     = cnt_q - 6'd1;
		prod_ext = {42'd0, prod_q};
		case (pcnt[1:0])
			2'd0:    prod_sh = prod_ext;
			2'd1:    prod_sh = prod_ext << 32;
			2'd2:    prod_sh = prod_ext << 32;
			default: prod_sh = prod_ext << 64;
		endcase
	end

	// restoring divide step
	logic        q_bit;
	logic [53:0] rem_sub, rem_next;
	logic [55:0] q_next;

	always_comb begin
		q_bit    = rem_q >= {1'b0, ma_q};
		rem_sub  = q_bit ? (rem_q - {1'b0, ma_q}) : rem_q;
		rem_next = {rem_sub[52:0], 1'b0};
		q_next   = {acc_q[54:0], q_bit};
	end

	// rounding
	logic [10:0] fld_exp;
	logic [62:0] fld;
	logic        g_bit, s_bit, rnd_up;

	always_comb begin
		fld_exp = acc_q[105] ? rexp_q[10:0] : 11'd0;
		fld     = {fld_exp, acc_q[104:53]};
		g_bit   = acc_q[52];
		s_bit   = (acc_q[51:0] != 52'd0) || stk_q;
		rnd_up  = g_bit && (s_bit || acc_q[53]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				F_IDLE: begin
					if (req.start) begin
						stk_q <= 1'b0;
						acc_q <= '0;
						cnt_q <= '0;
						if (req.op == OP_MUL) begin
							sign_q <= a_sign ^ b_sign;
							if (a_nan) begin
								res_q  <= a | (64'd1 << QUIET_BIT);
								done_q <= 1'b1;
							end else if (b_nan) begin
								res_q  <= b | (64'd1 << QUIET_BIT);
								done_q <= 1'b1;
							end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
								res_q  <= FP_NAN_DFLT;
								done_q <= 1'b1;
							end else if (a_inf || b_inf) begin
								res_q  <= {a_sign ^ b_sign, 11'h7FF, 52'd0};
								done_q <= 1'b1;
							end else if (a_zero || b_zero) begin
								res_q  <= {a_sign ^ b_sign, 63'd0};
								done_q <= 1'b1;
							end else begin
								ma_q   <= {(a_exp != 11'd0), a_frac};
								mb_q   <= {(b_exp != 11'd0), b_frac};
								rexp_q <= $signed({3'd0, a_eff}) + $signed({3'd0, b_eff})
									- 14'sd1022;
								st_q   <= F_MUL;
							end
						end else begin
							sign_q <= a_sign;
							if (a_nan) begin
								res_q  <= a | (64'd1 << QUIET_BIT);
								done_q <= 1'b1;
							end else if (a_inf) begin
								res_q  <= {a_sign, 63'd0};
								done_q <= 1'b1;
							end else if (a_zero) begin
								res_q  <= {a_sign, 11'h7FF, 52'd0};
								done_q <= 1'b1;
							end else begin
								ma_q   <= {(a_exp != 11'd0), a_frac};
								rexp_q <= $signed({3'd0, a_eff});
								st_q   <= F_DIVPRE;
							end
						end
					end
				end
				F_MUL: begin
					if (cnt_q != 6'd4) begin
						prod_q <= mul_x * mul_y;
					end
					if (cnt_q != 6'd0) begin
						acc_q <= acc_q + prod_sh;
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd4) begin
						st_q <= F_NORM;
					end
				end
				F_DIVPRE: begin
					if (!ma_q[52]) begin
						ma_q   <= {ma_q[51:0], 1'b0};
						rexp_q <= rexp_q - 14'sd1;
					end else begin
						rexp_q <= 14'sd2046 - rexp_q;
						rem_q  <= 54'd1 << 52;
						cnt_q  <= '0;
						st_q   <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= rem_next;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd55) begin
						acc_q <= {q_next, 49'd0, (rem_next != 54'd0)};
						st_q  <= F_NORM;
					end else begin
						acc_q <= {50'd0, q_next};
					end
				end
				F_NORM: begin
					if (!acc_q[105] && (rexp_q > 14'sd1)) begin
						acc_q  <= {acc_q[104:0], 1'b0};
						rexp_q <= rexp_q - 14'sd1;
					end else begin
						st_q <= F_DENORM;
					end
				end
				F_DENORM: begin
					if ((rexp_q < 14'sd1) && (acc_q != 106'd0)) begin
						stk_q  <= stk_q | acc_q[0];
						acc_q  <= {1'b0, acc_q[105:1]};
						rexp_q <= rexp_q + 14'sd1;
					end else begin
						st_q <= F_ROUND;
					end
				end
				F_ROUND: begin
					if (acc_q[105] && (rexp_q > 14'sd2046)) begin
						res_q <= {sign_q, 11'h7FF, 52'd0};
					end else begin
						res_q <= {sign_q, fld + {62'd0, rnd_up}};
					end
					done_q <= 1'b1;
					st_q   <= F_IDLE;
				end
				default: begin
					st_q <= F_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### hw/rtl/float64_integer_power.sv
// top level: square-and-multiply sequencer around the shared binary64 unit
// work: up to 60 multiplies for a 32-bit exponent, plus a reciprocal for a
// negative power, one word in flight
// flow: a new word is taken only after the last result is accepted; the shared
// 32x32 multiplier, normalize loop and one-bit-per-cycle divider in fpip_fpu set the pace
// reset: arst_n resets state machines and flags, not data registers; no memory to clear
module float64_integer_power
	import fpip_pkg::*;
#(
	parameter int unsigned EXP_BITS = EXP_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((64 + EXP_BITS + 7) / 8) * 8 - 1:0] s_tdata, // base_bits, power
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [63:0]                           m_tdata   // result_bits
);

	typedef enum logic [2:0] {
		T_IDLE,
		T_LOOP,
		T_SQ,
		T_MY,
		T_RC,
		T_OUT
	} tst_t;

	tst_t                st_q;
	logic [63:0]         x_q;
	logic [63:0]         y_q;
	logic [EXP_BITS-1:0] n_q;
	logic                neg_q;
	logic [63:0]         out_q;
	fpip_req_t           req_q;
	logic [63:0]         a_q;
	logic [63:0]         b_q;
	logic                fpu_done;
	logic [63:0]         fpu_res;

	logic [63:0]         in_base;
	logic [EXP_BITS-1:0] in_pow;
	logic                in_neg;
	logic [EXP_BITS-1:0] in_mag;

	always_comb begin
		in_base = s_tdata[63:0];
		in_pow  = s_tdata[64 +: EXP_BITS];
		in_neg  = in_pow[EXP_BITS-1];
		in_mag  = in_neg ? (~in_pow + {{(EXP_BITS-1){1'b0}}, 1'b1}) : in_pow;
	end

	fpip_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.a      (a_q),
		.b      (b_q),
		.done   (fpu_done),
		.res    (fpu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			req_q.start <= 1'b0;
			req_q.op    <= OP_MUL;
		end else begin
			req_q.start <= 1'b0;
			case (st_q)
				T_IDLE: begin
					if (s_tvalid) begin
						x_q   <= in_base;
						y_q   <= in_mag[0] ? in_base : FP_ONE;
						n_q   <= in_mag >> 1;
						neg_q <= in_neg;
						st_q  <= T_LOOP;
					end
				end
				T_LOOP: begin
					if (n_q == '0) begin
						if (neg_q) begin
							req_q.start <= 1'b1;
							req_q.op    <= OP_RECIP;
							a_q         <= y_q;
							b_q         <= y_q;
							st_q        <= T_RC;
						end else begin
							out_q <= y_q;
							st_q  <= T_OUT;
						end
					end else begin
						req_q.start <= 1'b1;
						req_q.op    <= OP_MUL;
						a_q         <= x_q;
						b_q         <= x_q;
						st_q        <= T_SQ;
					end
				end
				T_SQ: begin
					if (fpu_done) begin
						x_q <= fpu_res;
						if (n_q[0]) begin
							req_q.start <= 1'b1;
							req_q.op    <= OP_MUL;
							a_q         <= y_q;
							b_q         <= fpu_res;
							st_q        <= T_MY;
						end else begin
							n_q  <= n_q >> 1;
							st_q <= T_LOOP;
						end
					end
				end
				T_MY: begin
					if (fpu_done) begin
						y_q  <= fpu_res;
						n_q  <= n_q >> 1;
						st_q <= T_LOOP;
					end
				end
				T_RC: begin
					if (fpu_done) begin
						out_q <= fpu_res;
						st_q  <= T_OUT;
					end
				end
				T_OUT: begin
					if (m_tready) begin
						st_q <= T_IDLE;
					end
				end
				default: begin
					st_q <= T_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (st_q == T_IDLE);
	assign m_tvalid = (st_q == T_OUT);
	assign m_tdata  = out_q;

	a_out_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while a result waits");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_done |-> (st_q == T_SQ || st_q == T_MY || st_q == T_RC))
		else $error("unit finished with no operation pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
		else $error("sequencer did not start after accept");

	a_start_from_loop: assert property (@(posedge clk) disable iff (!arst_n)
		req_q.start |-> (st_q == T_SQ || st_q == T_MY || st_q == T_RC))
		else $error("unit started outside a wait state");

endmodule
